### hdl/mersenne_twister_generator_top_assert.svh
// Assertion macros shared by the generator modules.
`ifndef MERSENNE_TWISTER_GENERATOR_TOP_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MTG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mtg_pkg.sv
// Shared types, constants and word functions of the generator.
`default_nettype none
package mtg_pkg;

  localparam int STATE_LENGTH = 624;
  localparam int IDX_W        = 10;
  localparam int WORD_W       = 32;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(STATE_LENGTH - 1);
  localparam logic [IDX_W-1:0]  IDX_FULL  = IDX_W'(STATE_LENGTH);
  localparam logic [IDX_W-1:0]  FAR_SPAN  = IDX_W'(397);

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_SEED     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TW_PRIME,
    ST_TW_LOAD,
    ST_TW_RUN,
    ST_GEN_READ,
    ST_GEN_WAIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SEED_START,
    CMD_SEED_STEP,
    CMD_TW_PRIME,
    CMD_TW_LOAD,
    CMD_TW_STEP,
    CMD_GEN_READ,
    CMD_GEN_LOAD
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;   // word counter at last state word
    logic idx_full;   // every state word used
    logic out_free;   // output register can take a word this cycle
  } dp_status_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far,
                                                   input logic              legacy);
    logic [WORD_W-1:0] mixed;
    logic              sel;
    mixed = {cur[WORD_W-1], nxt[WORD_W-2:0]};
    sel   = legacy ? cur[0] : nxt[0];
    return far ^ (mixed >> 1) ^ (sel ? TWIST_MATRIX : '0);
  endfunction

  function automatic logic [WORD_W-1:0] seed_word(input logic [WORD_W-1:0] prev,
                                                  input logic [IDX_W-1:0]  idx);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] prod;
    x    = prev ^ (prev >> 30);
    prod = SEED_MULT * x;
    return prod + {{(WORD_W-IDX_W){1'b0}}, idx};
  endfunction

endpackage
`default_nettype wire

### hdl/mersenne_twister_generator_top.sv
// Top level of the MT19937 generator: controller plus datapath.
//
//  channel  | direction | tdata                       | tuser
//  ---------+-----------+-----------------------------+-------------------------------
//  s_axis   | in        | [31:0] seed_value           | [0] operation (0 gen, 1 seed)
//  m_axis   | out       | [31:0] random_word          | -
//  cfg      | in        | cfg_wdata [0] twist_mode    | write on cfg_we
//
// Generate: per transaction a RAM read, then temper into the output register.
// A generate that finds the state used up first twists it, one word
// per cycle through two RAM copies (next word on one port, far word on the other).
// Seed: the serial multiply recurrence (one word per cycle) over the whole state,
// followed by the whole-state twist. No result transaction.
// Reset (rst, synchronous) sets mode 0 and marks the state as used up; the state
// RAM itself is not cleared. A stalled m_axis only holds a generate in its final cycle;
// the finished word waits in the output register while the next transaction is taken.
`default_nettype none
module mersenne_twister_generator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] seed_value
  input  wire logic        s_tuser,   // [0] operation
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // [31:0] random_word
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata  // [0] twist_mode
);

  mtg_pkg::dp_cmd_t    cmd;
  mtg_pkg::dp_status_t status;

  mtg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  mtg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .seed_in   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

### hdl/mtg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/mtg_dp.sv
// Datapath: state RAMs, seed recurrence, twist unit, tempering and output register.
`default_nettype none
module mtg_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mtg_pkg::dp_cmd_t          cmd,
  output      mtg_pkg::dp_status_t       status,
  input  wire logic [mtg_pkg::WORD_W-1:0] seed_in,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_wdata,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [mtg_pkg::WORD_W-1:0] out_data
);

  logic                         twist_mode;
  logic [mtg_pkg::IDX_W-1:0]    read_index;
  logic [mtg_pkg::IDX_W-1:0]    cnt;
  logic [mtg_pkg::IDX_W-1:0]    addr_a;
  logic [mtg_pkg::IDX_W-1:0]    addr_b;
  logic [mtg_pkg::WORD_W-1:0]   prev;
  logic [mtg_pkg::WORD_W-1:0]   cur;

  logic                         ram_we;
  logic [mtg_pkg::IDX_W-1:0]    ram_waddr;
  logic [mtg_pkg::WORD_W-1:0]   ram_wdata;
  logic                         re_a;
  logic                         re_b;
  logic [mtg_pkg::IDX_W-1:0]    raddr_a;
  logic [mtg_pkg::IDX_W-1:0]    raddr_b;
  logic [mtg_pkg::WORD_W-1:0]   rdata_a;
  logic [mtg_pkg::WORD_W-1:0]   rdata_b;
  logic [mtg_pkg::WORD_W-1:0]   seed_next;
  logic [mtg_pkg::WORD_W-1:0]   twist_next;

  function automatic logic [mtg_pkg::IDX_W-1:0] wrap_inc(input logic [mtg_pkg::IDX_W-1:0] a);
    return (a == mtg_pkg::IDX_LAST) ? '0 : a + 1'b1;
  endfunction

  assign seed_next  = mtg_pkg::seed_word(prev, cnt);
  assign twist_next = mtg_pkg::twist_word(cur, rdata_a, rdata_b, twist_mode);

  assign status.cnt_last = (cnt == mtg_pkg::IDX_LAST);
  assign status.idx_full = (read_index == mtg_pkg::IDX_FULL);
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = twist_next;
    re_a      = 1'b0;
    re_b      = 1'b0;
    raddr_a   = addr_a;
    raddr_b   = addr_b;
    case (cmd)
      mtg_pkg::CMD_SEED_START: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed_in;
      end
      mtg_pkg::CMD_SEED_STEP: begin
        ram_we    = 1'b1;
        ram_wdata = seed_next;
      end
      mtg_pkg::CMD_TW_PRIME: begin
        re_a    = 1'b1;
        raddr_a = '0;
      end
      mtg_pkg::CMD_TW_LOAD: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = mtg_pkg::IDX_W'(1);
        raddr_b = mtg_pkg::FAR_SPAN;
      end
      mtg_pkg::CMD_TW_STEP: begin
        ram_we = 1'b1;
        re_a   = 1'b1;
        re_b   = 1'b1;
      end
      mtg_pkg::CMD_GEN_READ: begin
        re_a    = 1'b1;
        raddr_a = read_index;
      end
      default: begin
      end
    endcase
  end

  // Two copies of the state: port A serves current/next words, port B the far word.
  mtg_ram #(.WIDTH(mtg_pkg::WORD_W), .DEPTH(mtg_pkg::STATE_LENGTH)) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (re_a),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mtg_ram #(.WIDTH(mtg_pkg::WORD_W), .DEPTH(mtg_pkg::STATE_LENGTH)) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (re_b),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      twist_mode <= 1'b0;
      read_index <= mtg_pkg::IDX_FULL;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        twist_mode <= cfg_wdata;
      end
      if (cmd == mtg_pkg::CMD_GEN_LOAD) begin
        out_valid  <= 1'b1;
        read_index <= read_index + 1'b1;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (cmd == mtg_pkg::CMD_TW_STEP && status.cnt_last) begin
          read_index <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      mtg_pkg::CMD_SEED_START: begin
        prev <= seed_in;
        cnt  <= mtg_pkg::IDX_W'(1);
      end
      mtg_pkg::CMD_SEED_STEP: begin
        prev <= seed_next;
        cnt  <= cnt + 1'b1;
      end
      mtg_pkg::CMD_TW_PRIME: begin
        cnt <= '0;
      end
      mtg_pkg::CMD_TW_LOAD: begin
        cur    <= rdata_a;
        addr_a <= mtg_pkg::IDX_W'(2);
        addr_b <= mtg_pkg::FAR_SPAN + 1'b1;
      end
      mtg_pkg::CMD_TW_STEP: begin
        cur    <= rdata_a;
        addr_a <= wrap_inc(addr_a);
        addr_b <= wrap_inc(addr_b);
        cnt    <= cnt + 1'b1;
      end
      mtg_pkg::CMD_GEN_LOAD: begin
        out_data <= mtg_pkg::temper(rdata_a);
      end
      default: begin
      end
    endcase
  end

`include "mersenne_twister_generator_top_assert.svh"

  `MTG_ASSERT_NOW(a_load_only_when_free, clk, rst, cmd == mtg_pkg::CMD_GEN_LOAD, status.out_free, "output word overwritten before transfer")
  `MTG_ASSERT_NOW(a_index_in_range, clk, rst, 1'b1, read_index <= mtg_pkg::IDX_FULL, "read index beyond state length")
  `MTG_ASSERT_NOW(a_read_valid_index, clk, rst, cmd == mtg_pkg::CMD_GEN_READ, !status.idx_full, "word read from exhausted state")

endmodule
`default_nettype wire

### hdl/mtg_ctrl.sv
// Controller FSM: sequences seeding, whole-state twist and word reads.
`default_nettype none
module mtg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic                in_op,
  input  wire mtg_pkg::dp_status_t status,
  output      mtg_pkg::dp_cmd_t    cmd
);

  mtg_pkg::ctrl_state_t state;
  mtg_pkg::ctrl_state_t state_next;
  logic                 gen_pending;
  logic                 gen_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mtg_pkg::ST_IDLE;
      gen_pending <= 1'b0;
    end else begin
      state       <= state_next;
      gen_pending <= gen_pending_next;
    end
  end

  always_comb begin
    state_next       = state;
    gen_pending_next = gen_pending;
    cmd              = mtg_pkg::CMD_NONE;
    in_ready         = 1'b0;
    case (state)
      mtg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == mtg_pkg::OP_SEED) begin
            cmd              = mtg_pkg::CMD_SEED_START;
            gen_pending_next = 1'b0;
            state_next       = mtg_pkg::ST_SEED;
          end else if (status.idx_full) begin
            gen_pending_next = 1'b1;
            state_next       = mtg_pkg::ST_TW_PRIME;
          end else begin
            cmd        = mtg_pkg::CMD_GEN_READ;
            state_next = mtg_pkg::ST_GEN_WAIT;
          end
        end
      end
      mtg_pkg::ST_SEED: begin
        cmd = mtg_pkg::CMD_SEED_STEP;
        if (status.cnt_last) begin
          state_next = mtg_pkg::ST_TW_PRIME;
        end
      end
      mtg_pkg::ST_TW_PRIME: begin
        cmd        = mtg_pkg::CMD_TW_PRIME;
        state_next = mtg_pkg::ST_TW_LOAD;
      end
      mtg_pkg::ST_TW_LOAD: begin
        cmd        = mtg_pkg::CMD_TW_LOAD;
        state_next = mtg_pkg::ST_TW_RUN;
      end
      mtg_pkg::ST_TW_RUN: begin
        cmd = mtg_pkg::CMD_TW_STEP;
        if (status.cnt_last) begin
          gen_pending_next = 1'b0;
          state_next       = gen_pending ? mtg_pkg::ST_GEN_READ : mtg_pkg::ST_IDLE;
        end
      end
      mtg_pkg::ST_GEN_READ: begin
        cmd        = mtg_pkg::CMD_GEN_READ;
        state_next = mtg_pkg::ST_GEN_WAIT;
      end
      mtg_pkg::ST_GEN_WAIT: begin
        if (status.out_free) begin
          cmd        = mtg_pkg::CMD_GEN_LOAD;
          state_next = mtg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtg_pkg::ST_IDLE;
      end
    endcase
  end

`include "mersenne_twister_generator_top_assert.svh"

  `MTG_ASSERT_NEXT(a_twist_exit, clk, rst, state == mtg_pkg::ST_TW_RUN && status.cnt_last, state == mtg_pkg::ST_GEN_READ || state == mtg_pkg::ST_IDLE, "twist did not finish cleanly")
  `MTG_ASSERT_NEXT(a_seed_to_twist, clk, rst, state == mtg_pkg::ST_SEED && status.cnt_last, state == mtg_pkg::ST_TW_PRIME && !gen_pending, "seed fill not followed by twist")

endmodule
`default_nettype wire
